@@ hdl/base40_callsign_codec_assert.svh @@
// ----------------------------------------------------------------------------
// base40_callsign_codec_assert
// Assertion macros used by the checker file of the callsign codec.
// ----------------------------------------------------------------------------
`ifndef BASE40_CALLSIGN_CODEC_ASSERT_SVH
`define BASE40_CALLSIGN_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B40_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define B40_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/b40cc_pkg.sv @@
// ----------------------------------------------------------------------------
// b40cc_pkg
// Types, constants and symbol tables of the base-40 callsign codec.
// ----------------------------------------------------------------------------
package b40cc_pkg;

	// Number of character fields and of base-40 digits in a code.
	localparam int NCH = 9;
	// Characters taken by the encoder before it stops.
	localparam int MAX_CHARS = 9;
	localparam int CODE_W = 48;
	localparam int DIG_W = 6;
	localparam int CHR_W = 8;
	localparam int RADIX = 40;

	localparam logic [CODE_W-1:0] CODE_LIMIT = 48'hEE6B27FFFFFF;
	// Weight of the most significant digit, 40^8.
	localparam logic [CODE_W-1:0] TOP_W = 48'd6553600000000;

	localparam logic [DIG_W-1:0] SYM_DASH = 6'd37;
	localparam logic [DIG_W-1:0] SYM_SLASH = 6'd38;
	localparam logic [DIG_W-1:0] SYM_DOT = 6'd39;

	localparam logic OP_ENC = 1'b0;

	typedef struct packed {
		logic                           op;
		logic                           too_large;
		logic                           seen;
		logic [CODE_W-1:0]              val;
		logic [NCH-1:0][DIG_W-1:0]      dg;
		logic [NCH-1:0][CHR_W-1:0]      ch;
	} pipe_t;

	// Alphabet index of an ASCII character; anything unknown is 0.
	function automatic logic [DIG_W-1:0] sym_of(input logic [CHR_W-1:0] c);
		logic [CHR_W-1:0] t;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h40;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h15;
		end else if (c == 8'h2D) begin
			t = {2'b00, SYM_DASH};
		end else if (c == 8'h2F) begin
			t = {2'b00, SYM_SLASH};
		end else if (c == 8'h2E) begin
			t = {2'b00, SYM_DOT};
		end
		return t[DIG_W-1:0];
	endfunction

	// ASCII character of an alphabet index; indexes past the alphabet give NUL.
	function automatic logic [CHR_W-1:0] char_of(input logic [DIG_W-1:0] d);
		logic [CHR_W-1:0] c;
		logic [CHR_W-1:0] dx;
		dx = {2'b00, d};
		c = 8'h00;
		if (d == 6'd0) begin
			c = 8'h20;
		end else if (d <= 6'd26) begin
			c = 8'h40 + dx;
		end else if (d <= 6'd36) begin
			c = 8'h15 + dx;
		end else if (d == SYM_DASH) begin
			c = 8'h2D;
		end else if (d == SYM_SLASH) begin
			c = 8'h2F;
		end else if (d == SYM_DOT) begin
			c = 8'h2E;
		end
		return c;
	endfunction

endpackage

@@ hdl/b40cc_cell.sv @@
// ----------------------------------------------------------------------------
// b40cc_cell
// One base-40 digit step, most significant digit first, with its own word
// register and handshake to the next cell.
// ----------------------------------------------------------------------------
module b40cc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	output logic             in_rdy,
	input  b40cc_pkg::pipe_t in_data,
	output logic             out_vld,
	input  logic             out_rdy,
	output b40cc_pkg::pipe_t out_data
);

	b40cc_pkg::pipe_t                       nxt;
	logic [b40cc_pkg::DIG_W-1:0]            dig;
	logic [b40cc_pkg::CODE_W-1:0]           sub;
	logic [b40cc_pkg::CODE_W-1:0]           base;
	logic [b40cc_pkg::DIG_W-1:0]            add;
	logic                                   vld_q;
	b40cc_pkg::pipe_t                       data_q;

	assign in_rdy = !vld_q || out_rdy;

	always_comb begin
		// Top digit of the remainder: count the multiples of 40^8 not above it.
		dig = '0;
		sub = '0;
		for (int k = 1; k < b40cc_pkg::RADIX; k++) begin
			if (in_data.val >= b40cc_pkg::CODE_W'(k) * b40cc_pkg::TOP_W) begin
				dig = b40cc_pkg::DIG_W'(k);
				sub = b40cc_pkg::CODE_W'(k) * b40cc_pkg::TOP_W;
			end
		end

		// Encode runs Horner's rule; decode scales the remainder back up.
		if (in_data.op == b40cc_pkg::OP_ENC) begin
			base = in_data.val;
			add = in_data.dg[b40cc_pkg::NCH-1];
		end else begin
			base = in_data.val - sub;
			add = '0;
		end

		nxt = in_data;
		nxt.val = (base << 5) + (base << 3) + b40cc_pkg::CODE_W'(add);
		nxt.seen = in_data.seen || (in_data.op && dig != '0);

		for (int j = b40cc_pkg::NCH-1; j > 0; j--) begin
			nxt.dg[j] = in_data.dg[j-1];
		end
		nxt.dg[0] = '0;

		// Characters enter at slot 0 and move up, so the most significant
		// digit ends in the top slot.
		for (int j = b40cc_pkg::NCH-1; j > 0; j--) begin
			nxt.ch[j] = in_data.ch[j-1];
		end
		nxt.ch[0] = nxt.seen ? b40cc_pkg::char_of(dig) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_rdy) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			data_q <= nxt;
		end
	end

	assign out_vld = vld_q;
	assign out_data = data_q;

endmodule

@@ hdl/base40_callsign_codec.sv @@
// ----------------------------------------------------------------------------
// base40_callsign_codec
// Base-40 callsign encoder and decoder built as a row of digit cells.
// ----------------------------------------------------------------------------
// The codec takes one word per clock unless a stalled output backs up to its
// input. Each word passes one input register that looks up the alphabet
// symbols and checks the code range, then nine identical digit cells, one per
// base-40 digit, most significant first. Each cell has its own register and
// handshake, so a stalled output only blocks the cells that are full; the
// combinational ready path runs through all ten stages.
module base40_callsign_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  char_0,
	input  logic [7:0]  char_1,
	input  logic [7:0]  char_2,
	input  logic [7:0]  char_3,
	input  logic [7:0]  char_4,
	input  logic [7:0]  char_5,
	input  logic [7:0]  char_6,
	input  logic [7:0]  char_7,
	input  logic [7:0]  char_8,
	input  logic [47:0] code_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] code_out,
	output logic [7:0]  out_0,
	output logic [7:0]  out_1,
	output logic [7:0]  out_2,
	output logic [7:0]  out_3,
	output logic [7:0]  out_4,
	output logic [7:0]  out_5,
	output logic [7:0]  out_6,
	output logic [7:0]  out_7,
	output logic [7:0]  out_8,
	output logic        too_large
);

	logic [b40cc_pkg::NCH-1:0][b40cc_pkg::CHR_W-1:0] chars;
	logic [b40cc_pkg::NCH-1:0]                       alive;
	b40cc_pkg::pipe_t                                front;
	b40cc_pkg::pipe_t                                front_s1;
	logic                                            vld_s1;
	b40cc_pkg::pipe_t                                link [b40cc_pkg::NCH+1];
	logic                                            lvld [b40cc_pkg::NCH+1];
	logic                                            lrdy [b40cc_pkg::NCH+1];
	b40cc_pkg::pipe_t                                last;

	assign chars = {char_8, char_7, char_6, char_5, char_4, char_3, char_2, char_1, char_0};

	always_comb begin
		// A character counts only if it and every one before it are non-NUL.
		alive[0] = (0 < b40cc_pkg::MAX_CHARS) && (chars[0] != '0);
		for (int i = 1; i < b40cc_pkg::NCH; i++) begin
			alive[i] = (i < b40cc_pkg::MAX_CHARS) && (chars[i] != '0) && alive[i-1];
		end

		front = '0;
		front.op = op;
		if (op == b40cc_pkg::OP_ENC) begin
			for (int i = 0; i < b40cc_pkg::NCH; i++) begin
				front.dg[i] = alive[i] ? b40cc_pkg::sym_of(chars[i]) : '0;
			end
		end else if (code_in > b40cc_pkg::CODE_LIMIT) begin
			front.too_large = 1'b1;
		end else begin
			front.val = code_in;
		end
	end

	assign in_ready = !vld_s1 || lrdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			front_s1 <= front;
		end
	end

	assign link[0] = front_s1;
	assign lvld[0] = vld_s1;

	for (genvar g = 0; g < b40cc_pkg::NCH; g++) begin : g_cell
		b40cc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (lvld[g]),
			.in_rdy   (lrdy[g]),
			.in_data  (link[g]),
			.out_vld  (lvld[g+1]),
			.out_rdy  (lrdy[g+1]),
			.out_data (link[g+1])
		);
	end

	assign last = link[b40cc_pkg::NCH];
	assign lrdy[b40cc_pkg::NCH] = out_ready;
	assign out_valid = lvld[b40cc_pkg::NCH];

	assign code_out = (last.op == b40cc_pkg::OP_ENC) ? last.val : '0;
	assign too_large = last.too_large;
	assign out_0 = last.ch[0];
	assign out_1 = last.ch[1];
	assign out_2 = last.ch[2];
	assign out_3 = last.ch[3];
	assign out_4 = last.ch[4];
	assign out_5 = last.ch[5];
	assign out_6 = last.ch[6];
	assign out_7 = last.ch[7];
	assign out_8 = last.ch[8];

endmodule

@@ hdl/b40cc_checker.sv @@
// ----------------------------------------------------------------------------
// b40cc_checker
// Port-level checks of the callsign codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "base40_callsign_codec_assert.svh"

module b40cc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] code_out,
	input logic [7:0]  out_0,
	input logic [7:0]  out_8,
	input logic        too_large
);

	// A result word waiting on the output stays offered.
	`B40_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// An encoded word carries no decoded characters and no range flag.
	`B40_ASSERT_NOW(a_enc_clean, clk, arst_n, out_valid && code_out != '0,
		out_0 == '0 && out_8 == '0 && !too_large)

	// An out-of-range code decodes to nothing at all.
	`B40_ASSERT_NOW(a_big_empty, clk, arst_n, out_valid && too_large,
		out_0 == '0 && out_8 == '0 && code_out == '0)

	// Nine base-40 digits never exceed the largest valid code.
	`B40_ASSERT_NOW(a_code_range, clk, arst_n, out_valid,
		code_out <= b40cc_pkg::CODE_LIMIT)

endmodule

bind base40_callsign_codec b40cc_checker u_b40cc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.code_out  (code_out),
	.out_0     (out_0),
	.out_8     (out_8),
	.too_large (too_large)
);
